// ----- hdl/vhc_pkg.sv -----
// Types, codes and version helpers shared by the version handshake checker.
package vhc_pkg;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_PROTO = 4'd1,
    PH_APP   = 4'd2,
    PH_COMB  = 4'd3,
    PH_LEN   = 4'd4,
    PH_NAME  = 4'd5,
    PH_EXTRA = 4'd6,
    PH_DONE  = 4'd7,
    PH_CONN  = 4'd8,
    PH_ERR   = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_DATA   = 2'd1,
    MODE_FINISH = 2'd2
  } mode_t;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 64;

  localparam logic [CfgIndexWidth-1:0] CFG_LOCAL_PROTO = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_OWN_APP     = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_NAME_LEN    = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_NAME_LOW    = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_NAME_HIGH   = 3'd4;

  localparam logic [7:0] PEER_VERSION_RESET = 8'hF0;
  localparam logic [7:0] MIN_START_SIZE     = 8'd3;
  localparam logic [7:0] NAME_OFFSET        = 8'd4;
  localparam int         NameBytes          = 15;

  typedef struct packed {
    logic       accepted;
    phase_t     handshake_state;
    logic       connected;
    logic       connection_changed;
    logic       respond_needed;
    logic [7:0] negotiated_proto;
    logic [7:0] combined_app;
  } result_t;

  // Lower of the two max nibbles, higher of the two min nibbles.
  function automatic logic [7:0] merge_versions(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = a;
    if (r[7:4] > b[7:4]) r[7:4] = b[7:4];
    if (r[3:0] < b[3:0]) r[3:0] = b[3:0];
    return r;
  endfunction

  function automatic logic version_ok(input logic [7:0] v);
    return v[7:4] >= v[3:0];
  endfunction

endpackage

// ----- hdl/version_handshake_checker_core.sv -----
// Version handshake checker: parses a version message one beat at a time.
//
// The input channel (in_valid, in_stall) carries one beat per message byte,
// plus a start beat before the payload and a finish beat after it. Every
// accepted beat produces exactly one result beat on the output channel
// (out_valid, out_stall) reporting the handshake phase, the link flag and
// the negotiated versions after that beat.
// The checker accepts one beat per clock cycle while in_stall is low. The
// result of a beat is registered; the whole step is a single register stage
// of nibble compares and selects.
// Results pass through an output register backed by a one-entry skid
// register, so one further beat is taken while a result waits. in_stall is
// raised only while the skid register is occupied.
// Configuration writes (cfg_valid, cfg_ready) are always taken and must be
// issued only while the checker is idle. Unknown indices are ignored.
// Synchronous reset returns the phase to idle, drops the link, restores the
// configuration defaults and empties both result registers.
module version_handshake_checker_core #(
  parameter int MAX_NAME_LEN = 15
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vhc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [vhc_pkg::CfgDataWidth-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        mode,
  input  logic [7:0]                        msg_total_size,
  input  logic [7:0]                        data_byte,
  input  logic [7:0]                        byte_offset,
  input  logic                              finish_ok,
  input  logic                              is_request,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              accepted,
  output logic [3:0]                        handshake_state,
  output logic                              connected,
  output logic                              connection_changed,
  output logic                              respond_needed,
  output logic [7:0]                        negotiated_proto,
  output logic [7:0]                        combined_app
);
  import vhc_pkg::*;

  localparam logic [3:0] NameLenMax = 4'(MAX_NAME_LEN);

  logic [7:0]  local_proto_version;
  logic [7:0]  own_app_version;
  logic [3:0]  name_length;
  logic [63:0] name_bytes_low;
  logic [55:0] name_bytes_high;

  phase_t     phase, phase_next;
  logic       link_up, link_up_next;
  logic [7:0] proto_combined, proto_combined_next;
  logic [7:0] peer_version, peer_version_next;
  logic [7:0] app_combined, app_combined_next;
  logic [7:0] length_byte, length_byte_next;

  result_t res_next, out_res, skid_res;
  logic    skid_valid;
  logic    in_fire, out_fire;
  logic    load_from_skid, load_from_in, load_skid;

  logic [7:0] name_table [NameBytes];
  logic [3:0] len_used;
  logic [7:0] name_pos, extra_pos;
  logic       start_ok;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_proto_version <= 8'd17;
      own_app_version     <= 8'd17;
      name_length         <= 4'd0;
      name_bytes_low      <= 64'd0;
      name_bytes_high     <= 56'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOCAL_PROTO: local_proto_version <= cfg_data[7:0];
        CFG_OWN_APP:     own_app_version     <= cfg_data[7:0];
        CFG_NAME_LEN:    name_length         <= cfg_data[3:0];
        CFG_NAME_LOW:    name_bytes_low      <= cfg_data;
        CFG_NAME_HIGH:   name_bytes_high     <= cfg_data[55:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      name_table[i] = name_bytes_low[8*i +: 8];
    end
    for (int i = 8; i < NameBytes; i++) begin
      name_table[i] = name_bytes_high[8*(i-8) +: 8];
    end
  end

  assign len_used  = (name_length > NameLenMax) ? NameLenMax : name_length;
  assign name_pos  = byte_offset - NAME_OFFSET;
  assign extra_pos = byte_offset - NAME_OFFSET - {4'd0, length_byte[7:4]};
  assign start_ok  = msg_total_size >= MIN_START_SIZE;

  // Next state.
  always_comb begin
    phase_next          = phase;
    link_up_next        = link_up;
    proto_combined_next = proto_combined;
    peer_version_next   = peer_version;
    app_combined_next   = app_combined;
    length_byte_next    = length_byte;
    unique case (mode)
      MODE_START: begin
        if (start_ok) phase_next = PH_PROTO;
      end
      MODE_DATA: begin
        unique case (phase)
          PH_PROTO: begin
            proto_combined_next = merge_versions(local_proto_version, data_byte);
            phase_next = version_ok(proto_combined_next) ? PH_APP : PH_ERR;
          end
          PH_APP: begin
            peer_version_next = data_byte;
            phase_next = PH_COMB;
          end
          PH_COMB: begin
            peer_version_next = merge_versions(peer_version, data_byte);
            app_combined_next = merge_versions(own_app_version, peer_version_next);
            phase_next = version_ok(app_combined_next) ? PH_LEN : PH_ERR;
          end
          PH_LEN: begin
            length_byte_next = data_byte;
            phase_next = (len_used == data_byte[7:4]) ? PH_NAME : PH_ERR;
          end
          PH_NAME: begin
            if (name_pos >= {4'd0, len_used} || data_byte != name_table[name_pos[3:0]]) begin
              phase_next = PH_ERR;
            end else if ({1'b0, name_pos} + 9'd1 >= {5'd0, len_used}) begin
              phase_next = (length_byte[3:0] == 4'd0) ? PH_DONE : PH_EXTRA;
            end
          end
          PH_EXTRA: begin
            if ({1'b0, extra_pos} + 9'd1 >= {5'd0, length_byte[3:0]}) phase_next = PH_DONE;
          end
          default: phase_next = PH_ERR;
        endcase
      end
      MODE_FINISH: begin
        if (phase == PH_DONE && finish_ok) begin
          link_up_next = 1'b1;
          phase_next   = PH_CONN;
        end else begin
          link_up_next        = 1'b0;
          proto_combined_next = local_proto_version;
        end
      end
      default: begin
      end
    endcase
  end

  // Result of the current beat.
  always_comb begin
    res_next.accepted           = (mode == MODE_START) && start_ok;
    res_next.handshake_state    = phase_next;
    res_next.connected          = link_up_next;
    res_next.connection_changed = (mode == MODE_FINISH) && (link_up_next != link_up);
    res_next.respond_needed     = (mode == MODE_FINISH) && (phase == PH_DONE) && finish_ok &&
                                  is_request;
    res_next.negotiated_proto   = proto_combined_next;
    res_next.combined_app       = app_combined_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      link_up        <= 1'b0;
      proto_combined <= 8'd17;
      peer_version   <= PEER_VERSION_RESET;
      app_combined   <= 8'd17;
      length_byte    <= 8'd0;
    end else if (in_fire) begin
      phase          <= phase_next;
      link_up        <= link_up_next;
      proto_combined <= proto_combined_next;
      peer_version   <= peer_version_next;
      app_combined   <= app_combined_next;
      length_byte    <= length_byte_next;
    end
  end

  assign load_from_skid = (!out_valid || out_fire) && skid_valid;
  assign load_from_in   = (!out_valid || out_fire) && !skid_valid && in_fire;
  assign load_skid      = out_valid && !out_fire && in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (load_from_skid || load_from_in) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
      if (load_skid) begin
        skid_valid <= 1'b1;
      end else if (load_from_skid) begin
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_from_skid) begin
      out_res <= skid_res;
    end else if (load_from_in) begin
      out_res <= res_next;
    end
    if (load_skid) skid_res <= res_next;
  end

  assign accepted           = out_res.accepted;
  assign handshake_state    = out_res.handshake_state;
  assign connected          = out_res.connected;
  assign connection_changed = out_res.connection_changed;
  assign respond_needed     = out_res.respond_needed;
  assign negotiated_proto   = out_res.negotiated_proto;
  assign combined_app       = out_res.combined_app;

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register occupied while output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> !skid_valid)
    else $error("skid register did not drain when the output was taken");

  a_respond_connected: assert property (@(posedge clk) disable iff (rst)
    (out_valid && respond_needed) |-> (connected && handshake_state == PH_CONN))
    else $error("response flagged without a connected link");

  a_accept_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted) |-> (handshake_state == PH_PROTO && !connection_changed))
    else $error("accepted start beat did not open the protocol phase");

  a_link_tracks: assert property (@(posedge clk) disable iff (rst)
    (in_fire && mode == MODE_DATA) |=> $stable(link_up))
    else $error("data beat changed the link flag");
`endif

endmodule

// ----- bench/testbench.sv -----
// Testbench for the version handshake checker core with a self-contained status predictor.
`timescale 1ns / 100ps

module testbench;
  import vhc_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_PAST_LIST = 3'd5;
  localparam logic [CfgIndexWidth-1:0] CFG_TOP_INDEX = 3'd7;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               mode;
  logic [7:0]               msg_total_size;
  logic [7:0]               data_byte;
  logic [7:0]               byte_offset;
  logic                     finish_ok;
  logic                     is_request;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     accepted;
  logic [3:0]               handshake_state;
  logic                     connected;
  logic                     connection_changed;
  logic                     respond_needed;
  logic [7:0]               negotiated_proto;
  logic [7:0]               combined_app;

  version_handshake_checker_core uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .msg_total_size(msg_total_size),
    .data_byte(data_byte), .byte_offset(byte_offset), .finish_ok(finish_ok),
    .is_request(is_request), .out_valid(out_valid), .out_stall(out_stall),
    .accepted(accepted), .handshake_state(handshake_state), .connected(connected),
    .connection_changed(connection_changed), .respond_needed(respond_needed),
    .negotiated_proto(negotiated_proto), .combined_app(combined_app)
  );

  // Predictor copy of the configuration registers.
  logic [7:0]  local_proto_cfg;
  logic [7:0]  own_app_cfg;
  logic [3:0]  name_len_cfg;
  logic [63:0] name_lo_cfg;
  logic [55:0] name_hi_cfg;

  // Predictor copy of the handshake state.
  phase_t     hs_phase;
  logic       link_up;
  logic [7:0] proto_comb;
  logic [7:0] peer_ver;
  logic [7:0] app_comb;
  logic [7:0] len_byte;

  result_t pending_status[$];
  int      mismatch_count = 0;
  int      beats_sent = 0;
  int      burst_left = 0;
  bit      steady_input = 1'b0;
  int      stall_left = 0;
  int      stall_style = 0;
  int      stall_tick = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [7:0] combine_pair(input logic [7:0] ours, input logic [7:0] theirs);
    logic [3:0] hi;
    logic [3:0] lo;
    hi = (ours[7:4] < theirs[7:4]) ? ours[7:4] : theirs[7:4];
    lo = (ours[3:0] > theirs[3:0]) ? ours[3:0] : theirs[3:0];
    return {hi, lo};
  endfunction

  function automatic bit range_valid(input logic [7:0] v);
    return v[7:4] >= v[3:0];
  endfunction

  function automatic logic [7:0] own_name_char(input int i);
    if (i < 8) return name_lo_cfg[8*i +: 8];
    if (i < NameBytes) return name_hi_cfg[8*(i-8) +: 8];
    return 8'h00;
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic result_t advance_handshake(input logic [1:0] md, input logic [7:0] size,
                                                input logic [7:0] b, input logic [7:0] off,
                                                input logic fin, input logic req);
    result_t    r;
    logic       old_link;
    logic [7:0] pos;
    int         len;
    r = '0;
    old_link = link_up;
    len = int'(name_len_cfg);
    case (md)
      MODE_START: begin
        if (size >= MIN_START_SIZE) begin
          hs_phase = PH_PROTO;
          r.accepted = 1'b1;
        end
      end
      MODE_DATA: begin
        case (hs_phase)
          PH_PROTO: begin
            proto_comb = combine_pair(local_proto_cfg, b);
            if (range_valid(proto_comb)) hs_phase = PH_APP;
            else hs_phase = PH_ERR;
          end
          PH_APP: begin
            peer_ver = b;
            hs_phase = PH_COMB;
          end
          PH_COMB: begin
            peer_ver = combine_pair(peer_ver, b);
            app_comb = combine_pair(own_app_cfg, peer_ver);
            if (range_valid(app_comb)) hs_phase = PH_LEN;
            else hs_phase = PH_ERR;
          end
          PH_LEN: begin
            len_byte = b;
            if (len == b[7:4]) hs_phase = PH_NAME;
            else hs_phase = PH_ERR;
          end
          PH_NAME: begin
            pos = off - NAME_OFFSET;
            if (pos >= len || b != own_name_char(int'(pos))) begin
              hs_phase = PH_ERR;
            end else if (int'(pos) + 1 >= len) begin
              if (len_byte[3:0] == 4'd0) hs_phase = PH_DONE;
              else hs_phase = PH_EXTRA;
            end
          end
          PH_EXTRA: begin
            pos = off - NAME_OFFSET - {4'd0, len_byte[7:4]};
            if (int'(pos) + 1 >= int'(len_byte[3:0])) hs_phase = PH_DONE;
          end
          default: hs_phase = PH_ERR;
        endcase
      end
      MODE_FINISH: begin
        if (hs_phase == PH_DONE && fin) begin
          link_up = 1'b1;
          hs_phase = PH_CONN;
          r.respond_needed = req;
        end else begin
          link_up = 1'b0;
          proto_comb = local_proto_cfg;
        end
        r.connection_changed = (old_link != link_up);
      end
      default: ;
    endcase
    r.handshake_state = hs_phase;
    r.connected = link_up;
    r.negotiated_proto = proto_comb;
    r.combined_app = app_comb;
    return r;
  endfunction

  task automatic reset_predictor();
    local_proto_cfg = 8'd17;
    own_app_cfg = 8'd17;
    name_len_cfg = 4'd0;
    name_lo_cfg = '0;
    name_hi_cfg = '0;
    hs_phase = PH_IDLE;
    link_up = 1'b0;
    proto_comb = local_proto_cfg;
    peer_ver = PEER_VERSION_RESET;
    app_comb = own_app_cfg;
    len_byte = 8'd0;
  endtask

  task automatic send_beat(input logic [1:0] md, input logic [7:0] size, input logic [7:0] b,
                           input logic [7:0] off, input logic fin, input logic req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady_input) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= md;
    msg_total_size <= size;
    data_byte <= b;
    byte_offset <= off;
    finish_ok <= fin;
    is_request <= req;
    do @(posedge clk); while (in_stall);
    pending_status.push_back(advance_handshake(md, size, b, off, fin, req));
    if (md != MODE_SPARE) beats_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIndexWidth-1:0] idx,
                                input logic [CfgDataWidth-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LOCAL_PROTO: local_proto_cfg = val[7:0];
      CFG_OWN_APP:     own_app_cfg = val[7:0];
      CFG_NAME_LEN:    name_len_cfg = val[3:0];
      CFG_NAME_LOW:    name_lo_cfg = val;
      CFG_NAME_HIGH:   name_hi_cfg = val[55:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] message_byte(input int k, input int len, input int extra);
    bit faithful;
    faithful = ($urandom_range(0, 9) != 0);
    if (!faithful) return rnd8();
    if (k == 0) return local_proto_cfg;
    if (k < 3) return own_app_cfg;
    if (k == 3) return {len[3:0], extra[3:0]};
    if (k < 4 + len) return own_name_char(k - 4);
    return rnd8();
  endfunction

  task automatic send_handshake(input bit clean);
    int         len;
    int         extra;
    int         total;
    int         cut;
    int         k;
    logic [7:0] size;
    logic [7:0] off;
    logic       fin;
    len = int'(name_len_cfg);
    extra = $urandom_range(0, 6);
    total = 4 + len + extra;
    cut = clean ? total : $urandom_range(0, total - 1);
    if ($urandom_range(0, 3) == 0) size = 8'($urandom_range(3, 255));
    else size = 8'(total);
    send_beat(MODE_START, size, rnd8(), rnd8(), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
    for (k = 0; k < cut; k++) begin
      if ($urandom_range(0, 19) == 0) off = rnd8();
      else off = 8'(k);
      send_beat(MODE_DATA, rnd8(), message_byte(k, len, extra), off,
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    if (clean) fin = ($urandom_range(0, 9) != 0);
    else fin = 1'($urandom_range(0, 1));
    send_beat(MODE_FINISH, rnd8(), rnd8(), rnd8(), fin, 1'($urandom_range(0, 1)));
  endtask

  task automatic apply_setting(input int p);
    logic [3:0]  hi;
    logic [7:0]  lp;
    logic [7:0]  ap;
    logic [3:0]  nl;
    logic [63:0] lo_word;
    logic [63:0] hi_word;
    hi = 4'($urandom_range(0, 15));
    lp = {hi, 4'($urandom_range(0, hi))};
    hi = 4'($urandom_range(0, 15));
    ap = {hi, 4'($urandom_range(0, hi))};
    nl = 4'($urandom_range(1, 15));
    lo_word = {$urandom, $urandom};
    hi_word = {$urandom, $urandom};
    case (p)
      0: begin
        lp = 8'hF0; ap = 8'hF0; nl = 4'd15; lo_word = '1; hi_word = '1;
      end
      1: begin
        lp = 8'h00; ap = 8'h00; nl = 4'd0; lo_word = '0; hi_word = '0;
      end
      2: begin
        lp = 8'hFF; ap = 8'h0F;
      end
      default: ;
    endcase
    write_register(CFG_LOCAL_PROTO, {56'd0, lp});
    write_register(CFG_OWN_APP, {56'd0, ap});
    write_register(CFG_NAME_LEN, {60'd0, nl});
    write_register(CFG_NAME_LOW, lo_word);
    write_register(CFG_NAME_HIGH, hi_word);
  endtask

  task automatic test_closed_phases();
    send_beat(MODE_DATA, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    send_beat(MODE_START, 8'd2, 8'hFF, 8'hFF, 1'b1, 1'b1);
    send_beat(MODE_START, 8'd0, 8'h00, 8'h00, 1'b0, 1'b0);
    send_beat(MODE_SPARE, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
    send_beat(MODE_FINISH, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
  endtask

  task automatic test_connect_and_drop();
    wait_idle();
    write_register(CFG_LOCAL_PROTO, 64'hF0);
    write_register(CFG_OWN_APP, 64'hF3);
    write_register(CFG_NAME_LEN, 64'd2);
    write_register(CFG_NAME_LOW, 64'h0123_4567_89AB_CDEF);
    write_register(CFG_NAME_HIGH, 64'hA5FE_DCBA_9876_5432);
    write_register(CFG_PAST_LIST, '1);
    write_register(CFG_TOP_INDEX, '0);
    send_beat(MODE_START, MIN_START_SIZE, 8'h00, 8'h00, 1'b0, 1'b0);
    send_beat(MODE_DATA, 8'h00, 8'h52, 8'd0, 1'b0, 1'b1);
    send_beat(MODE_DATA, 8'h00, 8'h41, 8'd1, 1'b0, 1'b1);
    send_beat(MODE_DATA, 8'h00, 8'h63, 8'd2, 1'b0, 1'b1);
    send_beat(MODE_DATA, 8'h00, 8'h21, 8'd3, 1'b0, 1'b1);
    send_beat(MODE_DATA, 8'h00, own_name_char(0), 8'd4, 1'b0, 1'b1);
    send_beat(MODE_DATA, 8'h00, own_name_char(1), 8'd5, 1'b0, 1'b1);
    send_beat(MODE_DATA, 8'h00, 8'hFF, 8'd6, 1'b0, 1'b1);
    send_beat(MODE_FINISH, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1);
    send_beat(MODE_DATA, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    send_beat(MODE_FINISH, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
  endtask

  task automatic test_name_position();
    send_beat(MODE_START, 8'd255, 8'h00, 8'h00, 1'b0, 1'b0);
    send_beat(MODE_DATA, 8'hFF, 8'hF0, 8'd0, 1'b1, 1'b0);
    send_beat(MODE_DATA, 8'hFF, 8'h33, 8'd1, 1'b1, 1'b0);
    send_beat(MODE_DATA, 8'hFF, 8'h33, 8'd2, 1'b1, 1'b0);
    send_beat(MODE_DATA, 8'hFF, 8'h20, 8'd3, 1'b1, 1'b0);
    send_beat(MODE_DATA, 8'hFF, own_name_char(0), 8'd3, 1'b1, 1'b0);
  endtask

  task automatic test_random_traffic();
    int p;
    int quota;
    int choice;
    for (p = 0; p < 6; p++) begin
      wait_idle();
      apply_setting(p);
      steady_input = (p == 3);
      quota = beats_sent + 170;
      while (beats_sent < quota) begin
        choice = $urandom_range(0, 19);
        if (choice < 14) begin
          send_handshake(1'b1);
        end else if (choice < 17) begin
          send_handshake(1'b0);
        end else begin
          repeat ($urandom_range(1, 4))
            send_beat(2'($urandom_range(0, 3)), rnd8(), rnd8(), rnd8(),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
    end
    steady_input = 1'b0;
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 150);
    end
    stall_left--;
    stall_tick++;
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      2: out_stall <= (stall_tick % 5 < 2);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result beat, state %0d", $realtime, handshake_state);
      end else begin
        want = pending_status.pop_front();
        if (accepted !== want.accepted || handshake_state !== want.handshake_state ||
            connected !== want.connected || connection_changed !== want.connection_changed ||
            respond_needed !== want.respond_needed ||
            negotiated_proto !== want.negotiated_proto || combined_app !== want.combined_app)
        begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: expected acc %b st %0d conn %b chg %b resp %b proto %h app %h",
                     $realtime, want.accepted, want.handshake_state, want.connected,
                     want.connection_changed, want.respond_needed, want.negotiated_proto,
                     want.combined_app);
            $display("%0t: actual   acc %b st %0d conn %b chg %b resp %b proto %h app %h",
                     $realtime, accepted, handshake_state, connected, connection_changed,
                     respond_needed, negotiated_proto, combined_app);
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    mode = MODE_START;
    msg_total_size = 8'd0;
    data_byte = 8'd0;
    byte_offset = 8'd0;
    finish_ok = 1'b0;
    is_request = 1'b0;
    reset_predictor();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_closed_phases();
    test_connect_and_drop();
    test_name_position();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_status.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/vhc_pkg.sv
hdl/version_handshake_checker_core.sv
bench/testbench.sv
